[rtl/mwwp_pkg.sv]
`default_nettype none
package mwwp_pkg;

    // ring depth, kept a power of two so slot indexes wrap naturally
    localparam int WindowDepth = 64;
    localparam int AddrW       = $clog2(WindowDepth);
    localparam int CountW      = $clog2(WindowDepth + 1);

    localparam int BytesW = 48;
    localparam int TimeW  = 48;
    localparam int WidthW = 32;
    localparam int CfgW   = 48;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_MEMORY_LIMIT      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_INSTANT_WATERMARK = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_WATERMARK  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_WIDTH_US   = 3'd3;

    localparam logic [1:0] VERDICT_OK   = 2'd0;
    localparam logic [1:0] VERDICT_INT  = 2'd1;
    localparam logic [1:0] VERDICT_KILL = 2'd2;

    localparam logic [BytesW-1:0] LIMIT_RESET = {BytesW{1'b1}};
    localparam logic [WidthW-1:0] WIDTH_RESET = 32'd15000000;

    typedef struct packed {
        logic accept;    // append the new sample
        logic exp_load;  // fetch the oldest entry time
        logic expire;    // test and pop the oldest entry
        logic scan;      // step the peak scan
        logic finish;    // load the result register
    } t_cmd;

    typedef struct packed {
        logic expired;   // oldest entry lies outside the window
        logic scan_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[rtl/mwwp_ctrl.sv]
`default_nettype none
module mwwp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire mwwp_pkg::t_status i_status,
    output mwwp_pkg::t_cmd        o_cmd
);
    import mwwp_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EXP_START = 3'd1;
    localparam logic [2:0] ST_EXPIRE    = 3'd2;
    localparam logic [2:0] ST_SCAN      = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_EXP_START;
                end
            end
            ST_EXP_START: begin
                o_cmd.exp_load = 1'b1;
                n_state = ST_EXPIRE;
            end
            ST_EXPIRE: begin
                o_cmd.expire = 1'b1;
                if (!i_status.expired) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/mwwp_dp.sv]
`default_nettype none
module mwwp_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mwwp_pkg::t_cmd                i_cmd,
    output mwwp_pkg::t_status                  o_status,
    input  wire logic [mwwp_pkg::BytesW-1:0]   i_sample_bytes,
    input  wire logic [mwwp_pkg::TimeW-1:0]    i_sample_time_us,
    input  wire logic                          i_cfg_valid,
    input  wire logic [mwwp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [mwwp_pkg::CfgW-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_verdict,
    output logic [mwwp_pkg::BytesW-1:0]        o_window_peak_bytes,
    output logic [mwwp_pkg::CountW-1:0]        o_window_fill
);
    import mwwp_pkg::*;

    // configuration
    logic [BytesW-1:0] r_limit;
    logic [BytesW-1:0] r_inst_wm;
    logic [BytesW-1:0] r_win_wm;
    logic [WidthW-1:0] r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_inst_wm <= '0;
            r_win_wm  <= '0;
            r_width   <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MEMORY_LIMIT:      r_limit   <= i_cfg_data[BytesW-1:0];
                CFG_INSTANT_WATERMARK: r_inst_wm <= i_cfg_data[BytesW-1:0];
                CFG_WINDOW_WATERMARK:  r_win_wm  <= i_cfg_data[BytesW-1:0];
                CFG_WINDOW_WIDTH_US:   r_width   <= i_cfg_data[WidthW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ring memories
    logic [TimeW-1:0]  time_mem [WindowDepth];
    logic [BytesW-1:0] val_mem  [WindowDepth];
    logic [TimeW-1:0]  r_time_rd;
    logic [BytesW-1:0] r_val_rd;

    logic [AddrW-1:0]  r_head;
    logic [CountW-1:0] r_count;
    logic [AddrW-1:0]  n_head;
    logic [CountW-1:0] n_count;
    logic [TimeW-1:0]  r_now;
    logic              r_kill;
    logic [1:0]        r_latch;
    logic [BytesW-1:0] r_peak;
    logic [CountW-1:0] r_idx;
    logic              r_scan_vld;

    logic              full;
    logic [AddrW-1:0]  head_a;
    logic [CountW-1:0] count_a;
    logic [AddrW-1:0]  wr_addr;
    logic [AddrW-1:0]  time_rd_addr;
    logic [AddrW-1:0]  val_rd_addr;
    logic              expired;
    logic [TimeW:0]    time_end;
    logic              kill_now;
    logic              int_now;
    logic [1:0]        verdict_new;
    logic              scan_issue;

    assign full    = (r_count == CountW'(WindowDepth));
    assign head_a  = full ? r_head + AddrW'(1) : r_head;
    assign count_a = full ? CountW'(WindowDepth - 1) : r_count;
    assign wr_addr = head_a + count_a[AddrW-1:0];

    assign time_end = {1'b0, r_time_rd} + {{(TimeW + 1 - WidthW){1'b0}}, r_width};
    assign expired  = i_cmd.expire && (r_count != '0) && (time_end < {1'b0, r_now});

    assign kill_now = ({1'b0, i_sample_bytes} + {1'b0, r_inst_wm}) > {1'b0, r_limit};
    assign int_now  = ({1'b0, r_peak} + {1'b0, r_win_wm}) > {1'b0, r_limit};

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.accept) begin
            n_head  = head_a;
            n_count = count_a + CountW'(1);
        end else if (expired) begin
            n_head  = r_head + AddrW'(1);
            n_count = r_count - CountW'(1);
        end
    end

    // read the slot that will be oldest next cycle
    assign time_rd_addr = n_head;
    assign scan_issue   = i_cmd.scan && (r_idx != r_count);
    assign val_rd_addr  = r_head + r_idx[AddrW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            time_mem[wr_addr] <= i_sample_time_us;
        end
        r_time_rd <= time_mem[time_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            val_mem[wr_addr] <= i_sample_bytes;
        end
        r_val_rd <= val_mem[val_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now  <= i_sample_time_us;
            r_kill <= kill_now;
        end
    end

    // peak scan, one entry issued per cycle, compared in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_scan_vld <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.exp_load) begin
                r_idx      <= '0;
                r_scan_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_vld <= scan_issue;
                if (scan_issue) begin
                    r_idx <= r_idx + CountW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_load) begin
            r_peak <= '0;
        end else if (i_cmd.scan && r_scan_vld && (r_val_rd > r_peak)) begin
            r_peak <= r_val_rd;
        end
    end

    always_comb begin
        if (r_latch != VERDICT_OK) begin
            verdict_new = r_latch;
        end else if (r_kill) begin
            verdict_new = VERDICT_KILL;
        end else if (int_now) begin
            verdict_new = VERDICT_INT;
        end else begin
            verdict_new = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= VERDICT_OK;
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_latch     <= verdict_new;
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_verdict           <= verdict_new;
            o_window_peak_bytes <= r_peak;
            o_window_fill       <= r_count;
        end
    end

    assign o_status.expired   = expired;
    assign o_status.scan_done = (r_idx == r_count) && !r_scan_vld;
    assign o_status.out_free  = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

[rtl/memory_watchdog_window_peak_core.sv]
// flow: a request is taken while idle, entries that lie outside the window are then expired,
// the entries left (up to 64) are scanned for the peak, and the result is loaded into the
// output register once that is free; a new request is taken while the previous result
// still waits in the output register
// reset: synchronous active low; clears the ring pointers, latched verdict and result
// valid, and loads the configuration reset values; no clearing pass is needed
`default_nettype none
module memory_watchdog_window_peak_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mwwp_pkg::BytesW-1:0]   i_sample_bytes,
    input  wire logic [mwwp_pkg::TimeW-1:0]    i_sample_time_us,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_verdict,
    output logic [mwwp_pkg::BytesW-1:0]        o_window_peak_bytes,
    output logic [mwwp_pkg::CountW-1:0]        o_window_fill,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mwwp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [mwwp_pkg::CfgW-1:0]     i_cfg_data
);
    import mwwp_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mwwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mwwp_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_sample_bytes      (i_sample_bytes),
        .i_sample_time_us    (i_sample_time_us),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_verdict           (o_verdict),
        .o_window_peak_bytes (o_window_peak_bytes),
        .o_window_fill       (o_window_fill)
    );

endmodule
`default_nettype wire
